@@ rtl/wavhp_pkg.sv @@
// wavhp_pkg: shared constants and codes for the wave header parser
// no dependencies; used by wav_header_parse_deinterleave, wavhp_checker and testbench
package wavhp_pkg;

  localparam int unsigned MaxSampleBytesDef = 4;

  // header markers, as read little-endian into a 32-bit word
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] FmtLen  = 32'd16;
  localparam logic [32:0] RiffOfs = 33'd36;

  // byte positions of the last byte of each header field
  localparam logic [5:0] PosRiff     = 6'd3;
  localparam logic [5:0] PosRiffLen  = 6'd7;
  localparam logic [5:0] PosWave     = 6'd11;
  localparam logic [5:0] PosFmt      = 6'd15;
  localparam logic [5:0] PosFmtLen   = 6'd19;
  localparam logic [5:0] PosFormat   = 6'd21;
  localparam logic [5:0] PosChannels = 6'd23;
  localparam logic [5:0] PosRate     = 6'd27;
  localparam logic [5:0] PosByteRate = 6'd31;
  localparam logic [5:0] PosBits     = 6'd35;
  localparam logic [5:0] PosData     = 6'd39;
  localparam logic [5:0] PosLast     = 6'd43;

  // result kinds
  localparam logic [1:0] KindSample = 2'd0;
  localparam logic [1:0] KindHeader = 2'd1;
  localparam logic [1:0] KindError  = 2'd2;

  // mode register codes
  localparam logic [1:0] ModeMono   = 2'd0;
  localparam logic [1:0] ModeStereo = 2'd1;
  localparam logic [1:0] ModeLag    = 2'd2;

  // error codes
  localparam logic [3:0] ErrNotRiff    = 4'd0;
  localparam logic [3:0] ErrNotWave    = 4'd1;
  localparam logic [3:0] ErrFmtMarker  = 4'd2;
  localparam logic [3:0] ErrFmtLen     = 4'd3;
  localparam logic [3:0] ErrNotPcm     = 4'd4;
  localparam logic [3:0] ErrChannels   = 4'd5;
  localparam logic [3:0] ErrBitsBytes  = 4'd6;
  localparam logic [3:0] ErrBitsUnsup  = 4'd7;
  localparam logic [3:0] ErrRate       = 4'd8;
  localparam logic [3:0] ErrDataMarker = 4'd9;
  localparam logic [3:0] ErrMode       = 4'd10;
  localparam logic [3:0] ErrTruncated  = 4'd11;

  typedef enum logic [2:0] {
    PhHeader = 3'b001,
    PhData   = 3'b010,
    PhStop   = 3'b100
  } phase_e;

endpackage

@@ rtl/wav_header_parse_deinterleave.sv @@
// wav_header_parse_deinterleave: canonical PCM wave header check and channel split
// depends on wavhp_pkg
//
// Bytes of a wave file enter one per transfer on the slave stream. The 44-byte
// header is checked field by field as each field's last byte arrives; the first
// failure gives one error result (kind 2) and every later byte is dropped until
// reset. A good header gives one header result (kind 1) with channel count,
// bits, rate, data length and the length warning. Data bytes are then gathered
// a tick at a time (one sample per channel) and sent out as sample results,
// left byte then right byte from the lsb up, or mono bytes only; with mode 2
// the right channel of the first tick is dropped. A partial last tick is lost.
// A finished tick is copied into an emit buffer that sends one result per cycle
// while the consumer is ready and the next tick fills, so the input stalls only
// when a tick completes before the previous one has drained; with a ready
// consumer the sustained rate is one byte per cycle. There is no clearing pass
// after reset.
module wav_header_parse_deinterleave #(
  parameter int unsigned MAX_SAMPLE_BYTES = wavhp_pkg::MaxSampleBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_we_i,
  input  logic [1:0]  mode_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // file_byte
  input  logic        s_axis_tlast,   // final_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // channel[0], sample_byte[8:1], error_code[12:9], channel_count[14:13],
  // sample_bits[20:15], rate_hz[52:21], data_length[84:53], length_warning[85]
  output logic [87:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  localparam int unsigned Depth = 2 * MAX_SAMPLE_BYTES;
  localparam int unsigned IW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FW    = $clog2(Depth + 1);

  // control state
  wavhp_pkg::phase_e phase_q, phase_d;
  logic [1:0]  mode_q;
  logic [5:0]  pos_q;
  logic [31:0] acc_q;
  logic [31:0] riff_q, rate_q, brate_q;
  logic [1:0]  chan_q;
  logic [5:0]  bits_q;
  logic [FW-1:0] fill_q;
  logic        ftp_q;

  // tick store, written in interleaved order
  logic [7:0]  store_q [Depth];

  // header/error result slot
  logic        hv_q;
  logic        herr_q;
  logic [3:0]  hcode_q;
  logic [31:0] dlen_q;
  logic        warn_q;

  // emit buffer
  logic [7:0]    ebuf_q [Depth];
  logic [FW-1:0] ecnt_q;
  logic [IW-1:0] eidx_q;
  logic          einter_q;

  logic        in_acc, pop_e, tick_done, load, busy;
  logic [31:0] acc_d;
  logic [15:0] v;
  logic [37:0] prod;
  logic [38:0] rhs, lhs;
  logic        err_hit;
  logic [3:0]  err_code;
  logic [2:0]  bpc;
  logic [3:0]  tick_len;
  logic [IW-1:0] wslot;
  logic        inter;
  logic [7:0]  cur [Depth];
  logic [7:0]  nbuf [Depth];
  logic [FW-1:0] ncnt;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign acc_d  = {s_axis_tdata, acc_q[31:8]};
  assign v      = acc_d[31:16];
  assign prod   = 38'(rate_q) * 38'(v[5:0]);
  assign rhs    = (chan_q == 2'd2) ? {prod, 1'b0} : {1'b0, prod};
  assign lhs    = {4'b0, brate_q, 3'b0};

  // header field checks for the byte at pos_q
  always_comb begin
    err_hit  = 1'b0;
    err_code = wavhp_pkg::ErrNotRiff;
    unique case (pos_q)
      wavhp_pkg::PosRiff: begin
        err_hit  = (acc_d != wavhp_pkg::TagRiff);
        err_code = wavhp_pkg::ErrNotRiff;
      end
      wavhp_pkg::PosWave: begin
        err_hit  = (acc_d != wavhp_pkg::TagWave);
        err_code = wavhp_pkg::ErrNotWave;
      end
      wavhp_pkg::PosFmt: begin
        err_hit  = (acc_d != wavhp_pkg::TagFmt);
        err_code = wavhp_pkg::ErrFmtMarker;
      end
      wavhp_pkg::PosFmtLen: begin
        err_hit  = (acc_d != wavhp_pkg::FmtLen);
        err_code = wavhp_pkg::ErrFmtLen;
      end
      wavhp_pkg::PosFormat: begin
        err_hit  = (v != 16'd1);
        err_code = wavhp_pkg::ErrNotPcm;
      end
      wavhp_pkg::PosChannels: begin
        err_hit  = (v != 16'd1) && (v != 16'd2);
        err_code = wavhp_pkg::ErrChannels;
      end
      wavhp_pkg::PosBits: begin
        if (v[2:0] != 3'd0) begin
          err_hit  = 1'b1;
          err_code = wavhp_pkg::ErrBitsBytes;
        end else if ((v != 16'd8 && v != 16'd16 && v != 16'd24 && v != 16'd32) ||
                     (32'(v[15:3]) > MAX_SAMPLE_BYTES)) begin
          err_hit  = 1'b1;
          err_code = wavhp_pkg::ErrBitsUnsup;
        end else if (lhs != rhs) begin
          err_hit  = 1'b1;
          err_code = wavhp_pkg::ErrRate;
        end
      end
      wavhp_pkg::PosData: begin
        err_hit  = (acc_d != wavhp_pkg::TagData);
        err_code = wavhp_pkg::ErrDataMarker;
      end
      wavhp_pkg::PosLast: begin
        err_hit  = !((mode_q == wavhp_pkg::ModeMono && chan_q == 2'd1) ||
                     ((mode_q == wavhp_pkg::ModeStereo || mode_q == wavhp_pkg::ModeLag) &&
                      chan_q == 2'd2));
        err_code = wavhp_pkg::ErrMode;
      end
      default: ;
    endcase
    if (!err_hit && s_axis_tlast && pos_q < wavhp_pkg::PosLast) begin
      err_hit  = 1'b1;
      err_code = wavhp_pkg::ErrTruncated;
    end
  end

  // tick geometry and interleaved write slot
  assign bpc      = bits_q[5:3];
  assign tick_len = (chan_q == 2'd2) ? {bpc, 1'b0} : {1'b0, bpc};
  assign tick_done = (32'(fill_q) + 32'd1 == 32'(tick_len));
  assign wslot = (32'(fill_q) < 32'(bpc)) ? IW'(32'(fill_q) * 2)
                                          : IW'((32'(fill_q) - 32'(bpc)) * 2 + 1);
  assign inter = (chan_q == 2'd2) && !(mode_q == wavhp_pkg::ModeLag && ftp_q);

  always_comb begin
    for (int j = 0; j < Depth; j++) begin
      cur[j] = (IW'(j) == wslot) ? s_axis_tdata : store_q[j];
    end
    for (int k = 0; k < Depth; k++) begin
      if (inter) nbuf[k] = cur[k];
      else if (2 * k < Depth) nbuf[k] = cur[2 * k];
      else nbuf[k] = 8'h00;
    end
    ncnt = inter ? FW'(32'(bpc) * 2) : FW'(bpc);
  end

  // output side
  assign m_axis_tvalid = hv_q || (ecnt_q != '0);
  assign pop_e = m_axis_tready && !hv_q && (ecnt_q != '0);
  assign busy  = (ecnt_q != '0) && !(ecnt_q == FW'(1) && pop_e);
  assign s_axis_tready = !(phase_q == wavhp_pkg::PhData && tick_done && busy);
  assign load = in_acc && phase_q == wavhp_pkg::PhData && tick_done;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tlast = 1'b1;
    m_axis_tuser = wavhp_pkg::KindSample;
    if (hv_q) begin
      if (herr_q) begin
        m_axis_tuser       = wavhp_pkg::KindError;
        m_axis_tdata[12:9] = hcode_q;
      end else begin
        m_axis_tuser        = wavhp_pkg::KindHeader;
        m_axis_tdata[14:13] = chan_q;
        m_axis_tdata[20:15] = bits_q;
        m_axis_tdata[52:21] = rate_q;
        m_axis_tdata[84:53] = dlen_q;
        m_axis_tdata[85]    = warn_q;
      end
    end else begin
      m_axis_tdata[0]   = einter_q & eidx_q[0];
      m_axis_tdata[8:1] = ebuf_q[eidx_q];
      m_axis_tlast      = (ecnt_q == FW'(1));
    end
  end

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (in_acc) begin
      unique case (phase_q)
        wavhp_pkg::PhHeader: begin
          if (err_hit) phase_d = wavhp_pkg::PhStop;
          else if (pos_q == wavhp_pkg::PosLast)
            phase_d = s_axis_tlast ? wavhp_pkg::PhStop : wavhp_pkg::PhData;
        end
        wavhp_pkg::PhData: if (s_axis_tlast) phase_d = wavhp_pkg::PhStop;
        wavhp_pkg::PhStop: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wavhp_pkg::PhHeader;
      mode_q  <= wavhp_pkg::ModeMono;
      pos_q   <= '0;
      acc_q   <= '0;
      riff_q  <= '0;
      rate_q  <= '0;
      brate_q <= '0;
      chan_q  <= '0;
      bits_q  <= '0;
      fill_q  <= '0;
      ftp_q   <= 1'b1;
      hv_q    <= 1'b0;
      ecnt_q  <= '0;
      eidx_q  <= '0;
    end else begin
      phase_q <= phase_d;
      if (mode_we_i) mode_q <= mode_i;
      if (hv_q && m_axis_tready) hv_q <= 1'b0;
      if (in_acc && phase_q == wavhp_pkg::PhHeader) begin
        acc_q <= acc_d;
        pos_q <= pos_q + 6'd1;
        if (pos_q == wavhp_pkg::PosRiffLen)  riff_q  <= acc_d;
        if (pos_q == wavhp_pkg::PosRate)     rate_q  <= acc_d;
        if (pos_q == wavhp_pkg::PosByteRate) brate_q <= acc_d;
        if (pos_q == wavhp_pkg::PosChannels && !err_hit) chan_q <= v[1:0];
        if (pos_q == wavhp_pkg::PosBits && !err_hit) bits_q <= v[5:0];
        if (err_hit || pos_q == wavhp_pkg::PosLast) hv_q <= 1'b1;
      end
      if (in_acc && phase_q == wavhp_pkg::PhData) begin
        if (tick_done) begin
          fill_q <= '0;
          ftp_q  <= 1'b0;
        end else begin
          fill_q <= fill_q + FW'(1);
        end
      end
      if (load) begin
        ecnt_q <= ncnt;
        eidx_q <= '0;
      end else if (pop_e) begin
        ecnt_q <= ecnt_q - FW'(1);
        eidx_q <= eidx_q + IW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && phase_q == wavhp_pkg::PhHeader) begin
      herr_q  <= err_hit;
      hcode_q <= err_code;
      dlen_q  <= acc_d;
      warn_q  <= ({1'b0, acc_d} + wavhp_pkg::RiffOfs) != {1'b0, riff_q};
    end
    if (in_acc && phase_q == wavhp_pkg::PhData) store_q[wslot] <= s_axis_tdata;
    if (load) begin
      ebuf_q   <= nbuf;
      einter_q <= inter;
    end
  end

  // a tick never lands on an emit buffer that still holds results
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (ecnt_q == '0 || (ecnt_q == FW'(1) && pop_e)))
    else $error("emit buffer overrun");

  a_ready_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> phase_q == wavhp_pkg::PhData)
    else $error("input stalled outside data phase");

  a_hdr_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hv_q |-> phase_q != wavhp_pkg::PhHeader)
    else $error("header result while still in header");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ecnt_q) <= Depth)
    else $error("emit count out of range");

endmodule

@@ tb/wavhp_checker.sv @@
// wavhp_checker: watches both streams and the mode port of the wave header parser,
// predicts every result from the accepted file bytes and compares field by field
// depends on wavhp_pkg
module wavhp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        mode_we_i,
  input  logic [1:0]  mode_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // file_byte
  input  logic        s_axis_tlast,   // final_req
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // channel[0], sample_byte[8:1], error_code[12:9], channel_count[14:13],
  // sample_bits[20:15], rate_hz[52:21], data_length[84:53], length_warning[85]
  input  logic [87:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,   // kind
  input  logic        m_axis_tlast,   // last
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic        channel;
    logic [7:0]  sample_byte;
    logic [3:0]  error_code;
    logic [1:0]  channel_count;
    logic [5:0]  sample_bits;
    logic [31:0] rate_hz;
    logic [31:0] data_length;
    logic        length_warning;
    logic        last;
  } wav_result_t;

  wav_result_t expected_q[$];
  int          fail_count;

  // mirror of the parser state
  wavhp_pkg::phase_e phase;
  logic [1:0]  mode;
  logic [5:0]  hdr_pos;
  logic [31:0] shift_word;
  logic [31:0] riff_len;
  logic [31:0] rate_val;
  logic [31:0] byte_rate_val;
  logic [1:0]  chans;
  logic [5:0]  bits;
  logic [7:0]  tick_buf [8];
  logic [3:0]  tick_fill;
  logic        first_tick;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_q.size();

  function automatic wav_result_t blank_result(logic [1:0] kind);
    wav_result_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  task automatic parse_header_byte(input logic [7:0] b, input logic fin);
    logic [5:0]      pos;
    logic [15:0]     v;
    logic            bad;
    logic [3:0]      code;
    wav_result_t     r;
    longint unsigned lhs, rhs;
    pos        = hdr_pos;
    shift_word = {b, shift_word[31:8]};
    hdr_pos    = hdr_pos + 6'd1;
    v          = shift_word[31:16];
    bad        = 1'b0;
    code       = wavhp_pkg::ErrNotRiff;
    case (pos)
      wavhp_pkg::PosRiff: if (shift_word != wavhp_pkg::TagRiff) begin
        bad = 1'b1; code = wavhp_pkg::ErrNotRiff;
      end
      wavhp_pkg::PosRiffLen: riff_len = shift_word;
      wavhp_pkg::PosWave: if (shift_word != wavhp_pkg::TagWave) begin
        bad = 1'b1; code = wavhp_pkg::ErrNotWave;
      end
      wavhp_pkg::PosFmt: if (shift_word != wavhp_pkg::TagFmt) begin
        bad = 1'b1; code = wavhp_pkg::ErrFmtMarker;
      end
      wavhp_pkg::PosFmtLen: if (shift_word != wavhp_pkg::FmtLen) begin
        bad = 1'b1; code = wavhp_pkg::ErrFmtLen;
      end
      wavhp_pkg::PosFormat: if (v != 16'd1) begin
        bad = 1'b1; code = wavhp_pkg::ErrNotPcm;
      end
      wavhp_pkg::PosChannels: begin
        if (v < 16'd1 || v > 16'd2) begin
          bad  = 1'b1;
          code = wavhp_pkg::ErrChannels;
        end else begin
          chans = v[1:0];
        end
      end
      wavhp_pkg::PosRate:     rate_val = shift_word;
      wavhp_pkg::PosByteRate: byte_rate_val = shift_word;
      wavhp_pkg::PosBits: begin
        lhs = longint'(byte_rate_val) * 8;
        rhs = longint'(rate_val) * longint'(v) * longint'(chans);
        if (v[2:0] != 3'd0) begin
          bad  = 1'b1;
          code = wavhp_pkg::ErrBitsBytes;
        end else if (!(v == 16'd8 || v == 16'd16 || v == 16'd24 || v == 16'd32)
                     || v / 8 > wavhp_pkg::MaxSampleBytesDef) begin
          bad  = 1'b1;
          code = wavhp_pkg::ErrBitsUnsup;
        end else if (lhs != rhs) begin
          bad  = 1'b1;
          code = wavhp_pkg::ErrRate;
        end else begin
          bits = v[5:0];
        end
      end
      wavhp_pkg::PosData: if (shift_word != wavhp_pkg::TagData) begin
        bad = 1'b1; code = wavhp_pkg::ErrDataMarker;
      end
      wavhp_pkg::PosLast: begin
        if (!((mode == wavhp_pkg::ModeMono && chans == 2'd1) ||
              ((mode == wavhp_pkg::ModeStereo || mode == wavhp_pkg::ModeLag) &&
               chans == 2'd2))) begin
          bad  = 1'b1;
          code = wavhp_pkg::ErrMode;
        end
      end
      default: ;
    endcase
    // an early final byte only counts when nothing else failed on it
    if (!bad && fin && pos < wavhp_pkg::PosLast) begin
      bad  = 1'b1;
      code = wavhp_pkg::ErrTruncated;
    end
    if (bad) begin
      phase        = wavhp_pkg::PhStop;
      r            = blank_result(wavhp_pkg::KindError);
      r.error_code = code;
      expected_q.push_back(r);
    end else if (pos == wavhp_pkg::PosLast) begin
      phase            = fin ? wavhp_pkg::PhStop : wavhp_pkg::PhData;
      r                = blank_result(wavhp_pkg::KindHeader);
      r.channel_count  = chans;
      r.sample_bits    = bits;
      r.rate_hz        = rate_val;
      r.data_length    = shift_word;
      r.length_warning = ({1'b0, shift_word} + wavhp_pkg::RiffOfs) != {1'b0, riff_len};
      expected_q.push_back(r);
    end
  endtask

  task automatic split_data_byte(input logic [7:0] b, input logic fin);
    int          bpc, tick;
    wav_result_t r;
    bpc  = bits / 8;
    tick = bpc * chans;
    if (fin) phase = wavhp_pkg::PhStop;
    if (tick == 0 || tick > 8) return;
    tick_buf[tick_fill[2:0]] = b;
    tick_fill = tick_fill + 4'd1;
    if (tick_fill < tick) return;
    for (int i = 0; i < bpc; i++) begin
      r             = blank_result(wavhp_pkg::KindSample);
      r.sample_byte = tick_buf[i];
      expected_q.push_back(r);
      // lag correction drops the right channel of the first tick only
      if (chans == 2'd2 && !(mode == wavhp_pkg::ModeLag && first_tick)) begin
        r.channel     = 1'b1;
        r.sample_byte = tick_buf[(bpc + i) % 8];
        expected_q.push_back(r);
      end
    end
    tick_fill  = '0;
    first_tick = 1'b0;
  endtask

  task automatic predict_transfer(input logic [7:0] b, input logic fin);
    int          before_n;
    wav_result_t r;
    before_n = expected_q.size();
    if (phase == wavhp_pkg::PhHeader) parse_header_byte(b, fin);
    else if (phase == wavhp_pkg::PhData) split_data_byte(b, fin);
    if (expected_q.size() > before_n) begin
      r = expected_q[expected_q.size() - 1];
      r.last = 1'b1;
      expected_q[expected_q.size() - 1] = r;
    end
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    wav_result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with nothing expected: kind %0d", m_axis_tuser);
      fail_count++;
      return;
    end
    e = expected_q.pop_front();
    check_field("kind", e.kind, m_axis_tuser);
    check_field("channel", e.channel, m_axis_tdata[0]);
    check_field("sample_byte", e.sample_byte, m_axis_tdata[8:1]);
    check_field("error_code", e.error_code, m_axis_tdata[12:9]);
    check_field("channel_count", e.channel_count, m_axis_tdata[14:13]);
    check_field("sample_bits", e.sample_bits, m_axis_tdata[20:15]);
    check_field("rate_hz", e.rate_hz, m_axis_tdata[52:21]);
    check_field("data_length", e.data_length, m_axis_tdata[84:53]);
    check_field("length_warning", e.length_warning, m_axis_tdata[85]);
    check_field("last", e.last, m_axis_tlast);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      fail_count    = 0;
      phase         = wavhp_pkg::PhHeader;
      mode          = wavhp_pkg::ModeMono;
      hdr_pos       = '0;
      shift_word    = '0;
      riff_len      = '0;
      rate_val      = '0;
      byte_rate_val = '0;
      chans         = '0;
      bits          = '0;
      tick_fill     = '0;
      first_tick    = 1'b1;
    end else begin
      // a result can never come from the byte taken at the same edge
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) predict_transfer(s_axis_tdata, s_axis_tlast);
      if (mode_we_i) mode = mode_i;
    end
  end

endmodule

@@ tb/testbench.sv @@
// testbench: top of the wave header parser regression; builds one wave file per run,
// drives it with random gaps and back-pressure and gives the verdict
// depends on wavhp_pkg, wav_header_parse_deinterleave and wavhp_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        mode_we_i = 1'b0;
  logic [1:0]  mode_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // file_byte
  logic        s_axis_tlast = 1'b0; // final_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // channel[0], sample_byte[8:1], error_code[12:9], channel_count[14:13],
  // sample_bits[20:15], rate_hz[52:21], data_length[84:53], length_warning[85]
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;        // kind
  logic        m_axis_tlast;        // last

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  logic steady = 1'b0;              // no gaps on either side while set

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  wav_header_parse_deinterleave i_dut (
    .clk_i, .rst_ni, .mode_we_i, .mode_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  wavhp_checker i_checker (
    .clk_i, .rst_ni, .mode_we_i, .mode_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side back-pressure: ready is low with a probability of 9 percent unless steady is set
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one byte transfer; valid stays high between back-to-back transfers
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!steady && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // mode is written only with the block drained and quiet
  task automatic write_mode(input logic [1:0] m);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    mode_we_i <= 1'b1;
    mode_i    <= m;
    @(posedge clk_i);
    mode_we_i <= 1'b0;
  endtask

  logic [7:0]  hdr [44];
  logic [15:0] n_chans, n_bits;
  logic [31:0] rate, byte_rate, data_len, riff_len;
  logic [1:0]  hdr_mode;
  int          trunc_at, n_data;

  task automatic put_word(input int at, input logic [31:0] w);
    for (int i = 0; i < 4; i++) hdr[at + i] = w[8*i +: 8];
  endtask

  initial begin
    // canonical header with random but consistent fields
    n_chans  = $urandom_range(1, 2);
    n_bits   = 16'(8 * $urandom_range(1, 4));
    case ($urandom_range(0, 3))
      0:       rate = 32'd0;
      1:       rate = 32'd192000;
      default: rate = $urandom_range(1, 1 << 20);
    endcase
    byte_rate = 32'((longint'(rate) * n_bits * n_chans) / 8);
    case ($urandom_range(0, 3))
      0:       data_len = 32'hFFFF_FFFF;   // plus 36 does not fit the riff length
      1:       data_len = 32'd0;
      default: data_len = $urandom;
    endcase
    riff_len = ($urandom_range(0, 3) == 0) ? $urandom : data_len + 32'd36;
    put_word(0, wavhp_pkg::TagRiff);
    put_word(4, riff_len);
    put_word(8, wavhp_pkg::TagWave);
    put_word(12, wavhp_pkg::TagFmt);
    put_word(16, wavhp_pkg::FmtLen);
    put_word(20, {n_chans, 16'd1});
    put_word(24, rate);
    put_word(28, byte_rate);
    put_word(32, {n_bits, 16'(n_bits * n_chans / 8)});
    put_word(36, wavhp_pkg::TagData);
    put_word(40, data_len);
    hdr_mode = (n_chans == 16'd1) ? wavhp_pkg::ModeMono :
               ($urandom_range(0, 1) ? wavhp_pkg::ModeStereo : wavhp_pkg::ModeLag);

    // a fifth of the runs alter the header: a corrupted byte, an early final
    // byte or a mode that does not fit the channel count
    trunc_at = 99;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          int p;
          p = $urandom_range(0, 43);
          hdr[p] = hdr[p] ^ 8'($urandom_range(1, 255));
        end
        1: trunc_at = $urandom_range(0, 42);
        default: hdr_mode = (n_chans == 16'd1) ? 2'($urandom_range(1, 3))
                                               : wavhp_pkg::ModeMono;
      endcase
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_mode(hdr_mode);

    for (int i = 0; i < 44; i++) begin
      send_byte(hdr[i], i == trunc_at || i == 43 && $urandom_range(0, 19) == 0);
    end

    // data bytes in several phases, each phase starting with a new mode;
    // the first write comes before any tick completes, so lag mode, if written first, bites
    n_data = 52;
    for (int k = 0; k < 4; k++) begin
      write_mode(2'((hdr_mode + k + 1) % 4));
      steady = (k == 1);
      for (int j = 0; j < n_data / 4; j++) begin
        logic [7:0] b;
        b = (k == 0 && j == 0) ? 8'h00 : (k == 0 && j == 1) ? 8'hFF : 8'($urandom);
        send_byte(b, 1'b0);
      end
    end
    steady = 1'b0;
    // the final byte usually leaves a partial tick behind
    send_byte(8'($urandom), 1'b1);
    // bytes after the final one are dropped
    for (int j = 0; j < 3; j++) send_byte(8'($urandom), 1'b0);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ wav_header_parse_deinterleave.f @@
rtl/wavhp_pkg.sv
rtl/wav_header_parse_deinterleave.sv
tb/wavhp_checker.sv
tb/testbench.sv
